/* rtl/tua_pkg.sv */
`default_nettype none
package tua_pkg;

    // Unit pool
    localparam int NUM_UNITS = 7;
    localparam int UNIT_W    = 3;
    localparam int FIRST_OC  = 4;

    localparam logic [7:0] FREE_MARK = 8'hFF;

    // Request type codes
    localparam logic [2:0] REQ_PULSE   = 3'd0;
    localparam logic [2:0] REQ_PWM     = 3'd1;
    localparam logic [2:0] REQ_IRQ     = 3'd2;
    localparam logic [2:0] REQ_RELEASE = 3'd3;
    localparam logic [2:0] REQ_DONE    = 3'd4;

    // Resource codes
    localparam logic [3:0] RES_SOFT   = 4'd7;
    localparam logic [3:0] RES_ANY    = 4'd8;
    localparam logic [3:0] RES_ANY_HW = 4'd9;
    localparam logic [3:0] RES_ALL    = 4'd10;
    localparam logic [3:0] RES_UNITS  = 4'(NUM_UNITS);

    // Grant codes
    localparam logic [3:0] GRANT_SOFT = 4'd7;
    localparam logic [3:0] GRANT_NONE = 4'd8;

    // PWM period thresholds, microseconds
    localparam logic [31:0] PER_SOFT_MIN = 32'd65500;
    localparam logic [31:0] PER_LONG_MIN = 32'd30000;
    localparam logic [31:0] PER_SHORT_MAX = 32'd2040;

    // Unit groups: capture units 1-3, output-compare units, capture units
    localparam logic [NUM_UNITS-1:0] CAP_HI_MASK = 7'b0001110;
    localparam logic [NUM_UNITS-1:0] OC_MASK     = 7'b1110000;
    localparam logic [NUM_UNITS-1:0] CAP_MASK    = 7'b0001111;

    typedef logic [NUM_UNITS-1:0][7:0] t_holder_arr;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  pin;
        logic [3:0]  resource;
        logic        pps_capable;
        logic [31:0] pwm_period;
    } t_req;

    typedef struct packed {
        logic [3:0]           granted;
        logic [NUM_UNITS-1:0] freed_mask;
    } t_rsp;

    // Holder update for one request
    typedef struct packed {
        logic                 take_en;
        logic [UNIT_W-1:0]    take_unit;
        logic [NUM_UNITS-1:0] free_sel;
    } t_upd;

    typedef struct packed {
        logic              found;
        logic [UNIT_W-1:0] idx;
    } t_pick;

    // Lowest set bit of a unit vector
    function automatic t_pick first_set(input logic [NUM_UNITS-1:0] v);
        t_pick p;
        p.found = 1'b0;
        p.idx   = '0;
        for (int u = NUM_UNITS - 1; u >= 0; u--) begin
            if (v[u]) begin
                p.found = 1'b1;
                p.idx   = UNIT_W'(u);
            end
        end
        return p;
    endfunction

endpackage
`default_nettype wire

/* rtl/tua_if.sv */
`default_nettype none
// Request channel
interface tua_req_if;
    logic          valid;
    logic          ready;
    tua_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Result channel
interface tua_rsp_if;
    logic          valid;
    logic          ready;
    tua_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/tua_decide.sv */
`default_nettype none
// Allocation decision for one request against the current holder table
module tua_decide (
    input  wire tua_pkg::t_req       i_req,
    input  wire tua_pkg::t_holder_arr i_holder,
    output tua_pkg::t_rsp            o_rsp,
    output tua_pkg::t_upd            o_upd
);

    logic [tua_pkg::NUM_UNITS-1:0] free_v;
    logic [tua_pkg::NUM_UNITS-1:0] own_v;
    logic [tua_pkg::NUM_UNITS-1:0] usable_v;
    logic                          res_is_unit;
    logic [tua_pkg::UNIT_W-1:0]    res_unit;
    logic [3:0]                    no_pps_grant;
    logic                          per_soft;
    logic                          per_long;
    logic                          per_short;
    tua_pkg::t_pick                pk_free;
    tua_pkg::t_pick                pk_use;
    tua_pkg::t_pick                pk_cap_hi;
    tua_pkg::t_pick                pk_oc;
    tua_pkg::t_pick                pk_cap;

    // Per-unit status
    always_comb begin
        for (int u = 0; u < tua_pkg::NUM_UNITS; u++) begin
            free_v[u] = (i_holder[u] == tua_pkg::FREE_MARK);
            own_v[u]  = (i_holder[u] == i_req.pin);
        end
    end

    assign usable_v    = free_v | own_v;
    assign res_is_unit = (i_req.resource < tua_pkg::RES_UNITS);
    assign res_unit    = i_req.resource[tua_pkg::UNIT_W-1:0];

    assign no_pps_grant = (res_is_unit || i_req.resource == tua_pkg::RES_ANY_HW) ?
                          tua_pkg::GRANT_NONE : tua_pkg::GRANT_SOFT;

    assign per_soft  = (i_req.pwm_period > tua_pkg::PER_SOFT_MIN);
    assign per_long  = (i_req.pwm_period > tua_pkg::PER_LONG_MIN);
    assign per_short = (i_req.pwm_period <= tua_pkg::PER_SHORT_MAX);

    // Priority picks over the unit groups
    assign pk_free   = tua_pkg::first_set(free_v);
    assign pk_use    = tua_pkg::first_set(usable_v);
    assign pk_cap_hi = tua_pkg::first_set(usable_v & tua_pkg::CAP_HI_MASK);
    assign pk_oc     = tua_pkg::first_set(free_v & tua_pkg::OC_MASK);
    assign pk_cap    = tua_pkg::first_set(free_v & tua_pkg::CAP_MASK);

    // Request decode
    always_comb begin
        o_rsp.granted    = tua_pkg::GRANT_NONE;
        o_rsp.freed_mask = '0;
        o_upd.take_en    = 1'b0;
        o_upd.take_unit  = '0;
        o_upd.free_sel   = '0;

        unique case (i_req.req_type)
            tua_pkg::REQ_PULSE: begin
                if (!i_req.pps_capable) begin
                    o_rsp.granted = no_pps_grant;
                end else if (i_req.resource == tua_pkg::RES_SOFT) begin
                    o_rsp.granted = tua_pkg::GRANT_SOFT;
                end else if (pk_free.found) begin
                    o_upd.take_en   = 1'b1;
                    o_upd.take_unit = pk_free.idx;
                end
            end
            tua_pkg::REQ_PWM: begin
                if (i_req.resource == tua_pkg::RES_SOFT) begin
                    o_rsp.granted = tua_pkg::GRANT_SOFT;
                end else if (!i_req.pps_capable) begin
                    o_rsp.granted = no_pps_grant;
                end else if (per_soft) begin
                    o_rsp.granted = tua_pkg::GRANT_SOFT;
                end else if ((per_long || per_short) && pk_cap_hi.found) begin
                    o_upd.take_en   = 1'b1;
                    o_upd.take_unit = pk_cap_hi.idx;
                end else if (per_long) begin
                    o_rsp.granted = tua_pkg::GRANT_SOFT;
                end else if (pk_use.found) begin
                    o_upd.take_en   = 1'b1;
                    o_upd.take_unit = pk_use.idx;
                end else begin
                    o_rsp.granted = (i_req.resource == tua_pkg::RES_ANY_HW) ?
                                    tua_pkg::GRANT_NONE : tua_pkg::GRANT_SOFT;
                end
            end
            tua_pkg::REQ_IRQ: begin
                if (res_is_unit) begin
                    if (usable_v[res_unit]) begin
                        o_upd.take_en   = 1'b1;
                        o_upd.take_unit = res_unit;
                    end
                end else if (usable_v[0]) begin
                    o_upd.take_en   = 1'b1;
                    o_upd.take_unit = '0;
                end else if (pk_oc.found) begin
                    o_upd.take_en   = 1'b1;
                    o_upd.take_unit = pk_oc.idx;
                end else if (pk_cap.found) begin
                    o_upd.take_en   = 1'b1;
                    o_upd.take_unit = pk_cap.idx;
                end
            end
            tua_pkg::REQ_RELEASE: begin
                if (i_req.resource == tua_pkg::RES_ALL) begin
                    o_upd.free_sel = own_v;
                end else if (res_is_unit) begin
                    o_upd.free_sel[res_unit] = 1'b1;
                end
            end
            tua_pkg::REQ_DONE: begin
                if (res_is_unit) begin
                    o_upd.free_sel[res_unit] = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // A take always reports the unit; freeing reports only held units
        if (o_upd.take_en) begin
            o_rsp.granted = {1'b0, o_upd.take_unit};
        end
        o_rsp.freed_mask = o_upd.free_sel & ~free_v;
    end

endmodule
`default_nettype wire

/* rtl/tua_holders.sv */
`default_nettype none
// Holder pin per timer unit
module tua_holders (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_upd_en,
    input  wire tua_pkg::t_upd         i_upd,
    input  wire [7:0]                  i_pin,
    output tua_pkg::t_holder_arr       o_holder
);

    tua_pkg::t_holder_arr r_holder;
    tua_pkg::t_holder_arr n_holder;

    // Free wins over take; a request never does both
    always_comb begin
        n_holder = r_holder;
        for (int u = 0; u < tua_pkg::NUM_UNITS; u++) begin
            if (i_upd.free_sel[u]) begin
                n_holder[u] = tua_pkg::FREE_MARK;
            end else if (i_upd.take_en && i_upd.take_unit == tua_pkg::UNIT_W'(u)) begin
                n_holder[u] = i_pin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int u = 0; u < tua_pkg::NUM_UNITS; u++) begin
                r_holder[u] <= tua_pkg::FREE_MARK;
            end
        end else if (i_upd_en) begin
            r_holder <= n_holder;
        end
    end

    assign o_holder = r_holder;

endmodule
`default_nettype wire

/* rtl/timer_unit_allocator_unit.sv */
`default_nettype none
// Timer unit allocator: hands out seven timer units (capture units 0-3,
// output-compare units 4-6) to pins on pulse, PWM and interrupt claims,
// and frees them on release and completion requests. Every request beat
// gives exactly one result beat, in order. One request is taken per clock
// cycle while results are accepted; a request passes the input register and
// then the result register, and the holder table is updated at the edge that
// loads the result register.
// Back-pressure on the result channel stalls the input only once both
// registers are full.
module timer_unit_allocator_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tua_req_if.sink     i_req,
    tua_rsp_if.source   o_rsp
);

    logic                 r_in_valid;
    logic                 n_in_valid;
    tua_pkg::t_req        r_req;
    logic                 r_out_valid;
    logic                 n_out_valid;
    tua_pkg::t_rsp        r_rsp;
    logic                 advance;
    logic                 in_beat;
    tua_pkg::t_rsp        dec_rsp;
    tua_pkg::t_upd        dec_upd;
    tua_pkg::t_holder_arr holder;

    // Pipeline flow
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign in_beat     = i_req.valid && i_req.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_beat) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_req <= i_req.data;
        end
        if (advance) begin
            r_rsp <= dec_rsp;
        end
    end

    tua_decide u_decide (
        .i_req    (r_req),
        .i_holder (holder),
        .o_rsp    (dec_rsp),
        .o_upd    (dec_upd)
    );

    tua_holders u_holders (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd_en (advance),
        .i_upd    (dec_upd),
        .i_pin    (r_req.pin),
        .o_holder (holder)
    );

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

endmodule
`default_nettype wire

/* dv/testbench.sv */
module testbench;
    import tua_pkg::*;

    localparam logic [2:0] REQ_UNKNOWN  = 3'd7;
    localparam int         RANDOM_ITEMS = 600;
    localparam int         MAX_REPORTS  = 10;

    logic i_clk;
    logic i_rst_n;

    tua_req_if req_bus ();
    tua_rsp_if rsp_bus ();

    timer_unit_allocator_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Shadow holder table and outstanding work
    logic [7:0]  pin_of_unit [NUM_UNITS];
    t_req        pending_reqs [$];
    t_rsp        grants_due [$];
    int          items_queued = 0;
    int          beats_taken  = 0;
    int          mismatch_cnt = 0;

    // Handshake pacing
    int          req_wait  = 0;
    int          req_calm  = 0;
    int          rsp_wait  = 0;
    int          rsp_calm  = 0;
    logic        rsp_hold;
    logic        offering;
    t_rsp        grant_want;

    logic [7:0]  pin_pool [0:5];
    logic [31:0] period_marks [0:7];

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Wait before the next beat; now and then a run of back-to-back beats
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    function automatic logic unit_open(input int u, input logic [7:0] pin);
        return pin_of_unit[u] == FREE_MARK || pin_of_unit[u] == pin;
    endfunction

    function automatic logic [3:0] assign_unit(input int u, input logic [7:0] pin);
        pin_of_unit[u] = pin;
        return 4'(u);
    endfunction

    // Answer for a pin that cannot be routed to a hardware unit
    function automatic logic [3:0] unroutable_grant(input logic [3:0] res);
        return (res < RES_SOFT || res == RES_ANY_HW) ? GRANT_NONE : GRANT_SOFT;
    endfunction

    function automatic logic [NUM_UNITS-1:0] vacate_unit(input int u);
        logic [NUM_UNITS-1:0] bit_u;
        bit_u = '0;
        if (pin_of_unit[u] != FREE_MARK)
            bit_u[u] = 1'b1;
        pin_of_unit[u] = FREE_MARK;
        return bit_u;
    endfunction

    // Grant and freed units for one request, updating the shadow table
    function automatic t_rsp serve_request(input t_req r);
        t_rsp o;
        logic hit;
        logic cap_first;
        int   u;
        o.granted    = GRANT_NONE;
        o.freed_mask = '0;
        hit          = 1'b0;
        cap_first    = r.pwm_period > PER_LONG_MIN || r.pwm_period <= PER_SHORT_MAX;
        case (r.req_type)
            REQ_PULSE: begin
                if (!r.pps_capable) begin
                    o.granted = unroutable_grant(r.resource);
                end else if (r.resource == RES_SOFT) begin
                    o.granted = GRANT_SOFT;
                end else begin
                    for (u = 0; u < NUM_UNITS; u++) begin
                        if (!hit && pin_of_unit[u] == FREE_MARK) begin
                            o.granted = assign_unit(u, r.pin);
                            hit       = 1'b1;
                        end
                    end
                end
            end
            REQ_PWM: begin
                if (r.resource == RES_SOFT) begin
                    o.granted = GRANT_SOFT;
                end else if (!r.pps_capable) begin
                    o.granted = unroutable_grant(r.resource);
                end else if (r.pwm_period > PER_SOFT_MIN) begin
                    o.granted = GRANT_SOFT;
                end else begin
                    // short and long periods prefer capture units 1-3
                    if (cap_first) begin
                        for (u = 1; u < FIRST_OC; u++) begin
                            if (!hit && unit_open(u, r.pin)) begin
                                o.granted = assign_unit(u, r.pin);
                                hit       = 1'b1;
                            end
                        end
                        if (!hit && r.pwm_period > PER_LONG_MIN) begin
                            o.granted = GRANT_SOFT;
                            hit       = 1'b1;
                        end
                    end
                    for (u = 0; u < NUM_UNITS; u++) begin
                        if (!hit && unit_open(u, r.pin)) begin
                            o.granted = assign_unit(u, r.pin);
                            hit       = 1'b1;
                        end
                    end
                    if (!hit)
                        o.granted = (r.resource == RES_ANY_HW) ? GRANT_NONE : GRANT_SOFT;
                end
            end
            REQ_IRQ: begin
                if (r.resource < RES_UNITS) begin
                    if (unit_open(int'(r.resource), r.pin))
                        o.granted = assign_unit(int'(r.resource), r.pin);
                end else if (unit_open(0, r.pin)) begin
                    o.granted = assign_unit(0, r.pin);
                end else begin
                    // output-compare units first, then capture units
                    for (u = FIRST_OC; u < NUM_UNITS; u++) begin
                        if (!hit && pin_of_unit[u] == FREE_MARK) begin
                            o.granted = assign_unit(u, r.pin);
                            hit       = 1'b1;
                        end
                    end
                    for (u = 0; u < FIRST_OC; u++) begin
                        if (!hit && pin_of_unit[u] == FREE_MARK) begin
                            o.granted = assign_unit(u, r.pin);
                            hit       = 1'b1;
                        end
                    end
                end
            end
            REQ_RELEASE: begin
                if (r.resource == RES_ALL) begin
                    for (u = 0; u < NUM_UNITS; u++) begin
                        if (pin_of_unit[u] == r.pin)
                            o.freed_mask |= vacate_unit(u);
                    end
                end else if (r.resource < RES_UNITS) begin
                    o.freed_mask = vacate_unit(int'(r.resource));
                end
            end
            REQ_DONE: begin
                if (r.resource < RES_UNITS)
                    o.freed_mask = vacate_unit(int'(r.resource));
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic queue_req(input logic [2:0] kind, input logic [7:0] pin,
                             input logic [3:0] res, input logic pps,
                             input logic [31:0] per);
        t_req r;
        r.req_type    = kind;
        r.pin         = pin;
        r.resource    = res;
        r.pps_capable = pps;
        r.pwm_period  = per;
        pending_reqs.push_back(r);
        items_queued++;
    endtask

    task automatic wait_for_drain();
        while (beats_taken < items_queued || grants_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic log_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endtask

    // Request driver: predicts on every accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            req_wait = 0;
        end else begin
            offering = req_bus.valid;
            if (req_bus.valid && req_bus.ready) begin
                grants_due.push_back(serve_request(req_bus.data));
                beats_taken++;
                offering = 1'b0;
                req_wait = draw_wait(req_calm);
            end
            if (!offering) begin
                if (req_wait > 0) begin
                    req_wait--;
                end else if (pending_reqs.size() != 0) begin
                    req_bus.data <= pending_reqs.pop_front();
                    offering = 1'b1;
                end
            end
            req_bus.valid <= offering;
        end
    end

    // Result monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
            rsp_wait = 0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (grants_due.size() == 0) begin
                    log_mismatch($sformatf("unexpected result: granted %0d freed %b",
                                           rsp_bus.data.granted, rsp_bus.data.freed_mask));
                end else begin
                    grant_want = grants_due.pop_front();
                    if (rsp_bus.data.granted !== grant_want.granted)
                        log_mismatch($sformatf("granted: expected %0d, got %0d",
                                               grant_want.granted, rsp_bus.data.granted));
                    if (rsp_bus.data.freed_mask !== grant_want.freed_mask)
                        log_mismatch($sformatf("freed_mask: expected %b, got %b",
                                               grant_want.freed_mask,
                                               rsp_bus.data.freed_mask));
                end
                rsp_wait = draw_wait(rsp_calm);
            end else if (rsp_wait > 0) begin
                rsp_wait--;
            end
            rsp_bus.ready <= !rsp_hold && rsp_wait == 0;
        end
    end

    // Long result stall mid-run so the block fills and backs up its input
    initial begin
        rsp_hold = 1'b0;
        wait (beats_taken >= 120);
        @(posedge i_clk);
        rsp_hold <= 1'b1;
        repeat (60) @(posedge i_clk);
        rsp_hold <= 1'b0;
    end

    // Run limit
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        logic [2:0]  kind;
        logic [7:0]  pin;
        logic [3:0]  res;
        logic        pps;
        logic [31:0] per;
        int          pick;

        i_rst_n       = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.data  = '0;
        rsp_bus.ready = 1'b0;
        foreach (pin_of_unit[u])
            pin_of_unit[u] = FREE_MARK;
        pin_pool     = '{8'd0, 8'd17, 8'd90, 8'd200, 8'd254, 8'd255};
        period_marks = '{32'd0, 32'd2040, 32'd2041, 32'd30000,
                         32'd30001, 32'd65500, 32'd65501, 32'hFFFF_FFFF};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: pps rules, each period band, own-unit reuse, full table
        queue_req(REQ_PULSE,   8'd10,  RES_ANY,    1'b1, 32'd0);
        queue_req(REQ_PULSE,   8'd11,  4'd3,       1'b0, 32'd0);
        queue_req(REQ_PULSE,   8'd11,  RES_ANY,    1'b0, 32'd0);
        queue_req(REQ_PULSE,   8'd12,  RES_SOFT,   1'b1, 32'd0);
        queue_req(REQ_PWM,     8'd13,  RES_SOFT,   1'b0, 32'd0);
        queue_req(REQ_PWM,     8'd13,  RES_ANY,    1'b1, 32'hFFFF_FFFF);
        queue_req(REQ_PWM,     8'd20,  RES_ANY,    1'b1, 32'd65500);
        queue_req(REQ_PWM,     8'd21,  RES_ANY,    1'b1, 32'd0);
        queue_req(REQ_PWM,     8'd22,  RES_ANY,    1'b1, 32'd2041);
        queue_req(REQ_PWM,     8'd20,  RES_ANY,    1'b1, 32'd30001);
        queue_req(REQ_IRQ,     8'd30,  4'd5,       1'b0, 32'd0);
        queue_req(REQ_IRQ,     8'd31,  RES_ANY,    1'b0, 32'd0);
        queue_req(REQ_IRQ,     8'd32,  4'd4,       1'b1, 32'd0);
        queue_req(REQ_PULSE,   8'd255, RES_ANY,    1'b1, 32'd0);
        queue_req(REQ_PULSE,   8'd40,  RES_ANY,    1'b1, 32'd0);
        queue_req(REQ_PULSE,   8'd41,  RES_ANY,    1'b1, 32'd0);
        queue_req(REQ_PWM,     8'd42,  RES_ANY,    1'b1, 32'd40000);
        queue_req(REQ_PWM,     8'd42,  RES_ANY_HW, 1'b1, 32'd10000);
        queue_req(REQ_IRQ,     8'd42,  RES_ALL,    1'b1, 32'd0);
        queue_req(REQ_RELEASE, 8'd20,  RES_ALL,    1'b0, 32'd0);
        queue_req(REQ_RELEASE, 8'd99,  4'd0,       1'b0, 32'd0);
        queue_req(REQ_RELEASE, 8'd99,  4'd0,       1'b0, 32'd0);
        queue_req(REQ_DONE,    8'd0,   4'd6,       1'b0, 32'd0);
        queue_req(REQ_DONE,    8'd0,   4'd15,      1'b0, 32'd0);
        queue_req(REQ_RELEASE, 8'd0,   RES_SOFT,   1'b0, 32'd0);
        queue_req(REQ_UNKNOWN, 8'd10,  4'd0,       1'b1, 32'd0);

        // sender holds back until every result is in
        wait_for_drain();

        // Random: a small pin pool so claims, reuse and releases meet
        repeat (RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            pin  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                               : pin_pool[$urandom_range(0, 5)];
            pps  = ($urandom_range(0, 7) != 0);
            res  = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, 10));
            case ($urandom_range(0, 4))
                0:       per = $urandom_range(0, 2040);
                1:       per = $urandom_range(2041, 30000);
                2:       per = $urandom_range(30001, 65500);
                3:       per = period_marks[$urandom_range(0, 7)];
                default: per = $urandom;
            endcase
            if (pick < 22) begin
                kind = REQ_PULSE;
            end else if (pick < 44) begin
                kind = REQ_PWM;
            end else if (pick < 58) begin
                kind = REQ_IRQ;
            end else if (pick < 80) begin
                kind = REQ_RELEASE;
                if ($urandom_range(0, 1) == 0)
                    res = RES_ALL;
            end else if (pick < 95) begin
                kind = REQ_DONE;
                if ($urandom_range(0, 3) != 0)
                    res = 4'($urandom_range(0, NUM_UNITS - 1));
            end else begin
                kind = 3'($urandom_range(int'(REQ_DONE) + 1, int'(REQ_UNKNOWN)));
            end
            queue_req(kind, pin, res, pps, per);
        end

        wait_for_drain();
        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0 && grants_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
